FILE: rtl/nfb_pkg.sv
// nfb_pkg: shared types, constants and the crc-8 nibble update for the
// nibble frame builder. Depends on nothing; imported by all but nfb_checker.
package nfb_pkg;

  localparam int unsigned DefAddrNibbles = 8;
  localparam int unsigned QueueDepth     = 2;
  // sync(3) + selector + length(2) + patch + finish + crc(2) + end(2)
  localparam int unsigned FrameFixedLen  = 12;
  localparam int unsigned MaxLenW        = 9;

  localparam logic [MaxLenW-1:0] MAX_LEN_RESET = 9'd275;
  localparam logic [3:0]         SYNC_NIB      = 4'h5;
  localparam logic [3:0]         ZERO_NIB      = 4'h0;
  localparam logic [7:0]         CRC_POLY      = 8'h07;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_PAYLOAD,
    KIND_ERROR
  } kind_e;

  // command handed from the front to the back through the queue
  typedef struct packed {
    kind_e       kind;
    logic [3:0]  sel;
    logic [31:0] addr;
    logic [7:0]  len;
    logic [3:0]  patch;
    logic [3:0]  finish;
    logic [3:0]  nib;
    logic        last;
  } cmd_t;

  // nibble xored into the low bits, then eight shifts with poly 0x07
  function automatic logic [7:0] crc_nibble(input logic [7:0] crc, input logic [3:0] nib);
    logic [7:0] c;
    c = crc ^ {4'b0000, nib};
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/nfb_front.sv
// nfb_front: accepts input items, tracks frame and discard state and turns
// each item into at most one command for the back part. Depends on nfb_pkg.
module nfb_front #(
  parameter int unsigned ADDR_NIBBLES = nfb_pkg::DefAddrNibbles
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        action_i,
  input  logic [3:0]                  proto_select_i,
  input  logic [31:0]                 target_address_i,
  input  logic [7:0]                  payload_count_i,
  input  logic [3:0]                  patch_nibble_i,
  input  logic [3:0]                  finish_nibble_i,
  input  logic [3:0]                  payload_nibble_i,
  input  logic [nfb_pkg::MaxLenW-1:0] max_frame_len_i,
  output logic                        push_o,
  output nfb_pkg::cmd_t               cmd_o
);
  import nfb_pkg::*;

  localparam int unsigned TotW = $clog2(FrameFixedLen + ADDR_NIBBLES + 256) + 1;

  logic [7:0]      left_q, left_d;
  logic            open_q, open_d;
  logic            disc_q, disc_d;
  logic [TotW-1:0] total;
  logic            too_long;
  logic            last_nib;

  assign total    = TotW'(FrameFixedLen + ADDR_NIBBLES) + TotW'(payload_count_i);
  assign too_long = total > TotW'(max_frame_len_i);
  assign last_nib = (left_q == 8'd1);

  always_comb begin
    left_d      = left_q;
    open_d      = open_q;
    disc_d      = disc_q;
    push_o      = 1'b0;
    cmd_o.kind   = too_long ? KIND_ERROR : KIND_START;
    cmd_o.sel    = proto_select_i;
    cmd_o.addr   = target_address_i;
    cmd_o.len    = payload_count_i;
    cmd_o.patch  = patch_nibble_i;
    cmd_o.finish = finish_nibble_i;
    cmd_o.nib    = payload_nibble_i;
    cmd_o.last   = last_nib;
    if (accept_i) begin
      if (!action_i) begin
        // a start abandons whatever frame was open
        push_o = 1'b1;
        left_d = payload_count_i;
        open_d = !too_long && (payload_count_i != 8'd0);
        disc_d = too_long && (payload_count_i != 8'd0);
      end else if (disc_q) begin
        left_d = left_q - 8'd1;
        disc_d = !last_nib;
      end else if (open_q) begin
        push_o     = 1'b1;
        cmd_o.kind = KIND_PAYLOAD;
        left_d     = left_q - 8'd1;
        open_d     = !last_nib;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 8'd0;
      open_q <= 1'b0;
      disc_q <= 1'b0;
    end else begin
      left_q <= left_d;
      open_q <= open_d;
      disc_q <= disc_d;
    end
  end

endmodule

FILE: rtl/nfb_queue.sv
// nfb_queue: short command queue between the front and the back part.
// Depends on nfb_pkg for the command type.
module nfb_queue #(
  parameter int unsigned DEPTH = nfb_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nfb_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          head_valid_o,
  output nfb_pkg::cmd_t head_o
);
  import nfb_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o       = (count_q == CntW'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

endmodule

FILE: rtl/nfb_back.sv
// nfb_back: steps through the command at the queue head one nibble per
// cycle while the output is not stalled, keeps the crc and drives the output register. Depends on nfb_pkg.
module nfb_back #(
  parameter int unsigned ADDR_NIBBLES = nfb_pkg::DefAddrNibbles
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  nfb_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [3:0]    out_nibble_o,
  output logic          run_last_o,
  output logic          frame_end_o,
  output logic          too_long_o
);
  import nfb_pkg::*;

  localparam int unsigned HdrLen = 7 + ADDR_NIBBLES;
  localparam int unsigned StepW  = $clog2(HdrLen + 5 + 1);
  localparam int unsigned AddrBase = 4;

  localparam logic [2:0] TR_FINISH = 3'd0;
  localparam logic [2:0] TR_CRC_HI = 3'd1;
  localparam logic [2:0] TR_CRC_LO = 3'd2;
  localparam logic [2:0] TR_END    = 3'd4;

  logic [StepW-1:0] step_q, step_d;
  logic [7:0]       crc_q, crc_cur;
  logic [3:0]       finish_q;
  logic             ov_q;
  logic [3:0]       nib_q;
  logic             last_q, end_q, err_q;

  logic             advance, fire;
  logic             is_start, is_pay, is_err;
  logic             in_trailer;
  logic [StepW-1:0] tpos, ai;
  logic [3:0]       nib;
  logic             in_crc, job_end, fend;

  assign advance  = !ov_q || out_ready_i;
  assign fire     = head_valid_i && advance;
  assign is_start = (head_i.kind == KIND_START);
  assign is_pay   = (head_i.kind == KIND_PAYLOAD);
  assign is_err   = (head_i.kind == KIND_ERROR);

  assign in_trailer = is_start ? (step_q >= StepW'(HdrLen)) : (is_pay && step_q != '0);
  assign tpos       = is_start ? (step_q - StepW'(HdrLen)) : (step_q - StepW'(1));
  assign ai         = StepW'(ADDR_NIBBLES - 1) - (step_q - StepW'(AddrBase));
  assign crc_cur    = (is_start && step_q == '0) ? 8'h00 : crc_q;

  always_comb begin
    nib     = ZERO_NIB;
    in_crc  = 1'b0;
    fend    = 1'b0;
    job_end = 1'b0;
    if (is_err) begin
      job_end = 1'b1;
    end else if (in_trailer) begin
      case (tpos[2:0])
        TR_FINISH: begin
          nib    = is_start ? head_i.finish : finish_q;
          in_crc = 1'b1;
        end
        TR_CRC_HI: nib = crc_q[7:4];
        TR_CRC_LO: nib = crc_q[3:0];
        TR_END: begin
          fend    = 1'b1;
          job_end = 1'b1;
        end
        default: nib = ZERO_NIB;
      endcase
    end else if (is_pay) begin
      nib     = head_i.nib;
      in_crc  = 1'b1;
      job_end = !head_i.last;
    end else begin
      in_crc = 1'b1;
      if (step_q == StepW'(2)) begin
        nib = SYNC_NIB;
      end else if (step_q == StepW'(3)) begin
        nib = head_i.sel;
      end else if (step_q == StepW'(HdrLen - 3)) begin
        nib = head_i.len[7:4];
      end else if (step_q == StepW'(HdrLen - 2)) begin
        nib = head_i.len[3:0];
      end else if (step_q == StepW'(HdrLen - 1)) begin
        nib     = head_i.patch;
        job_end = (head_i.len != 8'd0);
      end else if (step_q >= StepW'(AddrBase) && ai < StepW'(8)) begin
        // address nibbles above the 32-bit field read as zero
        nib = head_i.addr[{ai[2:0], 2'b00} +: 4];
      end
    end
  end

  assign pop_o  = fire && job_end;
  assign step_d = job_end ? '0 : step_q + StepW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      crc_q    <= 8'h00;
      finish_q <= 4'h0;
      ov_q     <= 1'b0;
    end else begin
      if (fire) begin
        step_q <= step_d;
        if (in_crc) begin
          crc_q <= crc_nibble(crc_cur, nib);
        end
        if (is_start && step_q == '0) begin
          finish_q <= head_i.finish;
        end
      end
      if (fire) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      nib_q  <= nib;
      last_q <= job_end;
      end_q  <= fend;
      err_q  <= is_err;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_nibble_o = nib_q;
  assign run_last_o   = last_q;
  assign frame_end_o  = end_q;
  assign too_long_o   = err_q;

endmodule

FILE: rtl/nibble_frame_builder_crc8.sv
// nibble_frame_builder_crc8: top level of the nibble frame builder.
// Depends on nfb_pkg, nfb_front, nfb_queue and nfb_back.
//
// Usage:
//   s_axis carries input items: tuser selects start (0) or payload nibble (1),
//   tdata carries the header fields and the payload nibble.
//   m_axis carries the frame one nibble per transfer; tlast marks the last
//   nibble caused by one input item, tuser flags end of frame and length error.
//   cfg_* writes the frame length limit (nibbles); always ready.
// Path: each item's command is written into the queue, and its nibbles
//   are registered in the output register that drives m_axis.
// Throughput: payload nibbles pass at one per cycle while m_axis is not
//   stalled. A start emits the header, plus the trailer if its payload
//   is empty; the last payload nibble is followed by the trailer, and a
//   length error gives a single nibble. The back part emits one nibble per
//   cycle when not stalled; a two-entry command queue lets the input side
//   run ahead while a header burst drains. Items that discard payload or
//   arrive with no frame open give no transfer on m_axis.
// Reset: clears frame state, crc and queue; the limit returns to 275.
// Stalls: with m_axis_tready low the output register holds, the queue fills
//   and s_axis_tready drops once two commands are waiting.
module nibble_frame_builder_crc8 #(
  parameter int unsigned ADDR_NIBBLES = nfb_pkg::DefAddrNibbles
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // tdata: proto_select[3:0], target_address[35:4], payload_count[43:36],
  //        patch_nibble[47:44], finish_nibble[51:48], payload_nibble[55:52]
  input  logic [55:0]                 s_axis_tdata,
  // tuser: action
  input  logic                        s_axis_tuser,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: out_nibble[3:0], zero fill [7:4]
  output logic [7:0]                  m_axis_tdata,
  // tuser: frame_end[0], too_long[1]
  output logic [1:0]                  m_axis_tuser,
  output logic                        m_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [nfb_pkg::MaxLenW-1:0] cfg_data_i
);
  import nfb_pkg::*;

  logic [MaxLenW-1:0] max_len_q;
  logic               full, accept, push, pop, head_valid;
  cmd_t               cmd, head;
  logic [3:0]         out_nib;
  logic               fend, terr;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  nfb_front #(.ADDR_NIBBLES(ADDR_NIBBLES)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .action_i         (s_axis_tuser),
    .proto_select_i   (s_axis_tdata[3:0]),
    .target_address_i (s_axis_tdata[35:4]),
    .payload_count_i  (s_axis_tdata[43:36]),
    .patch_nibble_i   (s_axis_tdata[47:44]),
    .finish_nibble_i  (s_axis_tdata[51:48]),
    .payload_nibble_i (s_axis_tdata[55:52]),
    .max_frame_len_i  (max_len_q),
    .push_o           (push),
    .cmd_o            (cmd)
  );

  nfb_queue #(.DEPTH(QueueDepth)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  nfb_back #(.ADDR_NIBBLES(ADDR_NIBBLES)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_nibble_o (out_nib),
    .run_last_o   (m_axis_tlast),
    .frame_end_o  (fend),
    .too_long_o   (terr)
  );

  assign m_axis_tdata = {4'b0000, out_nib};
  assign m_axis_tuser = {terr, fend};

endmodule

FILE: rtl/nfb_checker.sv
// nfb_checker: port-level assertions for the nibble frame builder, bound to
// the top level. Depends only on its clock, reset and m_axis ports.
module nfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready
);

  // a stalled transfer keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("m_axis payload changed while stalled");

  // length error is a lone zero nibble closing its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && (m_axis_tdata == 8'h00)
      && !m_axis_tuser[0])
    else $error("malformed length error result");

  // end of frame is the trailing zero and the last nibble of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'h00))
    else $error("end of frame not a closing zero nibble");

  // the nibble before an end of frame is the first end zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser[0] |->
      $past(m_axis_tdata) == 8'h00)
    else $error("end pair not two zero nibbles");

endmodule

bind nibble_frame_builder_crc8 nfb_checker u_nfb_checker (.*);
